[rtl/core/kvca_pkg.sv]
package kvca_pkg;

  localparam int HEADS = 4;
  localparam int MAX_POSITIONS = 64;
  localparam int MAX_DIMS = 64;

  localparam int HEAD_W = 2;
  localparam int POS_W = 6;
  localparam int DIM_W = 6;
  localparam int ELEM_W = 16;
  localparam int RES_W = 32;
  localparam int CNT_W = 7;
  localparam int ACC_W = 40;
  localparam int DOT_W = 38;
  localparam int SCALE_W = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam int STORE_DEPTH = HEADS * MAX_POSITIONS * MAX_DIMS;
  localparam int ADDR_W = HEAD_W + POS_W + DIM_W;

  localparam logic [1:0] CMD_KEY = 2'd0;
  localparam logic [1:0] CMD_VALUE = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;
  localparam logic [1:0] CMD_WEIGHT = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_SCORE_SCALE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POSITIONS_USED = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIMS_USED = 2'd2;

  localparam logic KIND_SCORE = 1'b0;
  localparam logic KIND_OUTPUT = 1'b1;

endpackage

[rtl/core/kvca_if.sv]
interface kvca_in_if;
  logic                                  valid;
  logic                                  ready;
  logic [1:0]                            cmd;
  logic [kvca_pkg::HEAD_W-1:0]           head;
  logic [kvca_pkg::POS_W-1:0]            position;
  logic [kvca_pkg::DIM_W-1:0]            dim;
  logic signed [kvca_pkg::ELEM_W-1:0]    element;
  logic                                  last;
  modport source(output valid, cmd, head, position, dim, element, last, input ready);
  modport sink(input valid, cmd, head, position, dim, element, last, output ready);
endinterface

interface kvca_out_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  kind;
  logic [kvca_pkg::POS_W-1:0]            slot;
  logic signed [kvca_pkg::RES_W-1:0]     result;
  logic                                  run_end;
  modport source(output valid, kind, slot, result, run_end, input ready);
  modport sink(input valid, kind, slot, result, run_end, output ready);
endinterface

interface kvca_cfg_if;
  logic                                  valid;
  logic                                  ready;
  logic [kvca_pkg::CFG_IDX_W-1:0]        index;
  logic [kvca_pkg::CFG_DATA_W-1:0]       data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

[rtl/core/kv_cache_attention_engine_unit.sv]
// a query's last element starts a score run that gives one score per position in
// turn; a weight is accumulated into the output sums, and the closing weight then
// gives one output per dimension. throughput: one multiply-accumulate per cycle
// through the key/value read port in a run; stores take one item per cycle when idle.
// reset: synchronous active-low rst_n resets control, configuration registers and
// accumulator valid flags; key, value and query stores are undefined until written.
module kv_cache_attention_engine_unit (
  input  logic         clk,
  input  logic         rst_n,
  kvca_in_if.sink      in_ch,
  kvca_out_if.source   out_ch,
  kvca_cfg_if.sink     cfg_ch
);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_SC_RUN = 4'd1;
  localparam logic [3:0] ST_SC_W   = 4'd2;
  localparam logic [3:0] ST_SC_M2  = 4'd3;
  localparam logic [3:0] ST_SC_OUT = 4'd4;
  localparam logic [3:0] ST_WA_RUN = 4'd5;
  localparam logic [3:0] ST_WA_W   = 4'd6;
  localparam logic [3:0] ST_OUT_RD = 4'd7;
  localparam logic [3:0] ST_OUT_WT = 4'd8;

  localparam int PW = kvca_pkg::POS_W;
  localparam int DW = kvca_pkg::DIM_W;
  localparam int EW = kvca_pkg::ELEM_W;
  localparam int AW = kvca_pkg::ACC_W;
  localparam int CW = kvca_pkg::CNT_W;

  logic signed [EW-1:0] key_mem [kvca_pkg::STORE_DEPTH];
  logic signed [EW-1:0] val_mem [kvca_pkg::STORE_DEPTH];
  logic signed [EW-1:0] q_mem [kvca_pkg::MAX_DIMS];
  logic signed [AW-1:0] acc_mem [kvca_pkg::MAX_DIMS];
  logic [kvca_pkg::MAX_DIMS-1:0] acc_vld_r;

  logic [3:0] state_r;
  logic [kvca_pkg::SCALE_W-1:0] scale_r;
  logic [CW-1:0] pos_used_r, dims_used_r;
  logic [CW-1:0] s_lim, d_lim;

  logic [kvca_pkg::HEAD_W-1:0] h_r;
  logic [PW-1:0] row_r;
  logic [DW-1:0] k_r;
  logic signed [EW-1:0] e_r;
  logic last_r;
  logic head_ok;

  logic [kvca_pkg::ADDR_W-1:0] rd_addr;
  logic signed [EW-1:0] key_q, val_q, qb_q;
  logic signed [AW-1:0] acc_q;
  logic acc_vld_q;

  logic rd_v_r, rd_last_r;
  logic [DW-1:0] rd_k_r;
  logic pr_v_r, pr_last_r;
  logic [DW-1:0] pr_k_r;
  logic signed [2*EW-1:0] prod_r;
  logic signed [AW-1:0] accp_r;
  logic signed [AW:0] acc_sum;
  logic signed [AW-1:0] acc_new;
  logic signed [kvca_pkg::DOT_W-1:0] dot_r;
  logic dot_done_r;
  logic [34:0] plo_r;
  logic signed [35:0] phi_r;
  logic signed [55:0] sum_r;
  logic signed [55:0] sc_sh;
  logic signed [AW:0] out_rnd;
  logic signed [kvca_pkg::RES_W-1:0] sc_res, acc_res;

  logic out_valid_r;
  logic out_kind_r, out_end_r;
  logic [PW-1:0] out_slot_r;
  logic signed [kvca_pkg::RES_W-1:0] out_result_r;
  logic slot_free;
  logic in_acc;
  logic is_score;

  function automatic logic signed [31:0] sat32(input logic signed [55:0] v);
    if (v > 56'sd2147483647) return 32'sh7fffffff;
    if (v < -56'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  assign s_lim = (pos_used_r == '0) ? CW'(1) :
                 (pos_used_r > CW'(kvca_pkg::MAX_POSITIONS)) ? CW'(kvca_pkg::MAX_POSITIONS) :
                 pos_used_r;
  assign d_lim = (dims_used_r == '0) ? CW'(1) :
                 (dims_used_r > CW'(kvca_pkg::MAX_DIMS)) ? CW'(kvca_pkg::MAX_DIMS) :
                 dims_used_r;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign slot_free = !out_valid_r || out_ch.ready;
  assign is_score = (state_r == ST_SC_RUN) || (state_r == ST_SC_W);
  assign head_ok = (32'(h_r) < kvca_pkg::HEADS);

  assign out_ch.valid = out_valid_r;
  assign out_ch.kind = out_kind_r;
  assign out_ch.slot = out_slot_r;
  assign out_ch.result = out_result_r;
  assign out_ch.run_end = out_end_r;

  assign rd_addr = {h_r, row_r, k_r};

  // stores
  always_ff @(posedge clk) begin
    if (in_acc && in_ch.cmd == kvca_pkg::CMD_KEY &&
        32'(in_ch.head) < kvca_pkg::HEADS) begin
      key_mem[{in_ch.head, in_ch.position, in_ch.dim}] <= in_ch.element;
    end
    key_q <= key_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_ch.cmd == kvca_pkg::CMD_VALUE &&
        32'(in_ch.head) < kvca_pkg::HEADS) begin
      val_mem[{in_ch.head, in_ch.position, in_ch.dim}] <= in_ch.element;
    end
    val_q <= val_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_ch.cmd == kvca_pkg::CMD_QUERY) begin
      q_mem[in_ch.dim] <= in_ch.element;
    end
    qb_q <= q_mem[k_r];
  end

  always_ff @(posedge clk) begin
    if (pr_v_r && !is_score) begin
      acc_mem[pr_k_r] <= acc_new;
    end
    acc_q <= acc_mem[k_r];
  end

  // multiply and accumulate
  always_comb begin
    acc_sum = 41'(accp_r) + 41'(prod_r);
    if (acc_sum > 41'sd549755813887) acc_new = 40'sh7fffffffff;
    else if (acc_sum < -41'sd549755813888) acc_new = 40'sh8000000000;
    else acc_new = acc_sum[AW-1:0];
    sc_sh = sum_r >>> 24;
    sc_res = sat32(sc_sh);
    out_rnd = ((acc_vld_q ? 41'(acc_q) : 41'sd0) + 41'sd2048) >>> 12;
    acc_res = sat32(56'(out_rnd));
  end

  always_ff @(posedge clk) begin
    rd_k_r <= k_r;
    acc_vld_q <= acc_vld_r[k_r];
    pr_k_r <= rd_k_r;
    pr_last_r <= rd_last_r;
    if (is_score) begin
      prod_r <= qb_q * (head_ok ? key_q : EW'(0));
    end else begin
      prod_r <= e_r * (head_ok ? val_q : EW'(0));
    end
    accp_r <= acc_vld_q ? acc_q : AW'(0);
    plo_r <= dot_r[18:0] * scale_r;
    phi_r <= $signed(dot_r[37:19]) * $signed({1'b0, scale_r});
    sum_r <= (56'(phi_r) <<< 19) + $signed({21'd0, plo_r}) + 56'sd8388608;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      scale_r <= 16'd4096;
      pos_used_r <= CW'(kvca_pkg::MAX_POSITIONS);
      dims_used_r <= CW'(kvca_pkg::MAX_DIMS);
      acc_vld_r <= '0;
      rd_v_r <= 1'b0;
      rd_last_r <= 1'b0;
      pr_v_r <= 1'b0;
      dot_done_r <= 1'b0;
      out_valid_r <= 1'b0;
      k_r <= '0;
      row_r <= '0;
      h_r <= '0;
      dot_r <= '0;
    end else begin
      if (cfg_ch.valid) begin
        case (cfg_ch.index)
          kvca_pkg::REG_SCORE_SCALE: scale_r <= cfg_ch.data;
          kvca_pkg::REG_POSITIONS_USED: pos_used_r <= cfg_ch.data[CW-1:0];
          kvca_pkg::REG_DIMS_USED: dims_used_r <= cfg_ch.data[CW-1:0];
          default: ;
        endcase
      end

      rd_v_r <= (state_r == ST_SC_RUN) || (state_r == ST_WA_RUN);
      rd_last_r <= (k_r == DW'(d_lim - CW'(1)));
      pr_v_r <= rd_v_r;
      dot_done_r <= pr_v_r && pr_last_r && is_score;
      if (pr_v_r && is_score) dot_r <= dot_r + kvca_pkg::DOT_W'(prod_r);
      if (pr_v_r && !is_score) acc_vld_r[pr_k_r] <= 1'b1;

      if (out_ch.ready) out_valid_r <= 1'b0;

      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            h_r <= in_ch.head;
            e_r <= in_ch.element;
            last_r <= in_ch.last;
            k_r <= '0;
            dot_r <= '0;
            if (in_ch.cmd == kvca_pkg::CMD_QUERY && in_ch.last) begin
              row_r <= '0;
              state_r <= ST_SC_RUN;
            end else if (in_ch.cmd == kvca_pkg::CMD_WEIGHT) begin
              row_r <= in_ch.position;
              if (CW'(in_ch.position) < s_lim) state_r <= ST_WA_RUN;
              else if (in_ch.last) state_r <= ST_OUT_RD;
            end
          end
        end
        ST_SC_RUN: begin
          if (k_r == DW'(d_lim - CW'(1))) state_r <= ST_SC_W;
          else k_r <= k_r + DW'(1);
        end
        ST_SC_W: begin
          if (dot_done_r) state_r <= ST_SC_M2;
        end
        ST_SC_M2: state_r <= ST_SC_OUT;
        ST_SC_OUT: begin
          if (slot_free) begin
            out_valid_r <= 1'b1;
            out_kind_r <= kvca_pkg::KIND_SCORE;
            out_slot_r <= row_r;
            out_result_r <= sc_res;
            out_end_r <= (CW'(row_r) == s_lim - CW'(1));
            k_r <= '0;
            dot_r <= '0;
            if (CW'(row_r) == s_lim - CW'(1)) begin
              state_r <= ST_IDLE;
            end else begin
              row_r <= row_r + PW'(1);
              state_r <= ST_SC_RUN;
            end
          end
        end
        ST_WA_RUN: begin
          if (k_r == DW'(d_lim - CW'(1))) state_r <= ST_WA_W;
          else k_r <= k_r + DW'(1);
        end
        ST_WA_W: begin
          if (pr_v_r && pr_last_r) begin
            k_r <= '0;
            state_r <= last_r ? ST_OUT_RD : ST_IDLE;
          end
        end
        ST_OUT_RD: state_r <= ST_OUT_WT;
        ST_OUT_WT: begin
          if (slot_free) begin
            out_valid_r <= 1'b1;
            out_kind_r <= kvca_pkg::KIND_OUTPUT;
            out_slot_r <= k_r;
            out_result_r <= acc_res;
            out_end_r <= (CW'(k_r) == d_lim - CW'(1));
            if (CW'(k_r) == d_lim - CW'(1)) begin
              acc_vld_r <= '0;
              k_r <= '0;
              state_r <= ST_IDLE;
            end else begin
              k_r <= k_r + DW'(1);
              state_r <= ST_OUT_RD;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule
